// ===== hdl/primitive_bounds_accumulator_top_macros.svh =====
// Assertion macros for the primitive bounds accumulator checker.
// Needs signals clk and arst_n in the scope of each use.
`ifndef PRIMITIVE_BOUNDS_ACCUMULATOR_TOP_MACROS_SVH
`define PRIMITIVE_BOUNDS_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pba_pkg.sv =====
// Shared types, constants and saturating helpers for the bounds accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package pba_pkg;

	// coordinate format: signed Q16.16
	localparam int COORD_BITS = 32;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	// padding register
	localparam int PAD_W = 16;
	typedef logic [PAD_W-1:0] pad_t;
	localparam pad_t PAD_RESET = pad_t'(1);

	// register port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_PAD_AMOUNT = '0;

	typedef enum logic [1:0] {
		CMD_SPHERE = 2'd0,
		CMD_QUAD   = 2'd1,
		CMD_TRI    = 2'd2,
		CMD_MERGE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t   cmd;
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		logic   last;
	} item_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	// word between front and back
	typedef struct packed {
		box_t box;
		logic last;
	} qword_t;

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic [COORD_BITS:0] s;
		s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
		if (s[COORD_BITS] != s[COORD_BITS-1]) begin
			return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
		end
		return coord_t'(s[COORD_BITS-1:0]);
	endfunction

	function automatic coord_t sat_sub(input coord_t a, input coord_t b);
		logic [COORD_BITS:0] s;
		s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (s[COORD_BITS] != s[COORD_BITS-1]) begin
			return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
		end
		return coord_t'(s[COORD_BITS-1:0]);
	endfunction

	// |r|, with the most negative value clamped to the most positive
	function automatic coord_t abs_sat(input coord_t r);
		if (r == COORD_MIN) begin
			return COORD_MAX;
		end
		return r[COORD_BITS-1] ? coord_t'(-r) : r;
	endfunction

	function automatic coord_t smin(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t smax(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/primitive_bounds_accumulator_top.sv =====
// Top level of the primitive bounds accumulator: register port and wiring.
// Depends on pba_pkg, pba_front, pba_queue and pba_back.
`default_nettype none

// Takes one primitive or child-box word per cycle while full is low and unions
// its box into the node box; a word with last set emits the node box and clears
// it. Sustained rate is one word per cycle when nothing stalls, set by the
// five-stage front pipeline and the combinational union in the back end. A
// taken word passes front stages s1 to s5 into the queue; a last word's result
// then goes through the queue and the result register. full rises only when
// the queue is full and the front's final stage holds a word; the queue keeps
// taking words while a result waits to be popped. pad_amount is written at
// word address 0 and should only change while no words are in flight.
module primitive_bounds_accumulator_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  pba_pkg::item_t              item,
	input  logic                        pop,
	output logic                        empty,
	output pba_pkg::box_t               box,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pba_pkg::ADDR_W-1:0]  paddr,
	input  logic [pba_pkg::DATA_W-1:0]  pwdata,
	output logic [pba_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import pba_pkg::*;

	pad_t                 pad_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 q_full, q_push, q_pop, q_nempty;
	qword_t               q_wdata, q_rdata;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_PAD_AMOUNT) ?
		{{(DATA_W-PAD_W){1'b0}}, pad_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= PAD_RESET;
		end else if (cfg_wr && (reg_idx == REG_PAD_AMOUNT)) begin
			pad_q <= pwdata[PAD_W-1:0];
		end
	end

	pba_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.pad     (pad_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	pba_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.nempty (q_nempty)
	);

	pba_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_nempty (q_nempty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.box      (box)
	);

endmodule

`default_nettype wire

// ===== hdl/pba_front.sv =====
// Front pipeline: takes input words, builds each item's padded box.
// Depends on pba_pkg; feeds pba_queue.
`default_nettype none

module pba_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pba_pkg::item_t  item,
	output logic            full,
	input  pba_pkg::pad_t   pad,
	input  logic            q_full,
	output logic            q_push,
	output pba_pkg::qword_t q_wdata
);
	import pba_pkg::*;

	logic   advance;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	item_t  item_s1;
	cmd_t   cmd_s2;
	logic   last_s2, last_s3, last_s4, last_s5;
	logic   padable_s3, padable_s4;
	coord_t a_s2 [3];
	coord_t c_s2 [3];
	coord_t b_s2 [3];
	coord_t q1_s2 [3];
	coord_t q2_s2 [3];
	coord_t r_s2;
	coord_t pt_s3 [3][4];
	coord_t lo_s4 [3];
	coord_t hi_s4 [3];
	coord_t lo_s5 [3];
	coord_t hi_s5 [3];
	logic   narrow_s5 [3];

	coord_t a [3];
	coord_t b [3];
	coord_t c [3];
	coord_t q1 [3];
	coord_t q2 [3];
	coord_t q3 [3];
	coord_t slo [3];
	coord_t shi [3];
	coord_t pt [3][4];
	coord_t lo [3];
	coord_t hi [3];
	logic   narrow [3];
	coord_t lo_o [3];
	coord_t hi_o [3];
	coord_t pad_c;

	// whole pipe holds while the last stage waits on the queue
	assign advance = !(v_s5 && q_full);
	assign full    = !advance;
	assign q_push  = v_s5 && !q_full;
	assign pad_c   = coord_t'({{(COORD_BITS-PAD_W){1'b0}}, pad});

	// stage 1: edge sums and sphere radius
	always_comb begin
		a = '{item_s1.a_x, item_s1.a_y, item_s1.a_z};
		b = '{item_s1.b_x, item_s1.b_y, item_s1.b_z};
		c = '{item_s1.c_x, item_s1.c_y, item_s1.c_z};
		for (int i = 0; i < 3; i++) begin
			q1[i] = sat_add(a[i], b[i]);
			q2[i] = sat_add(a[i], c[i]);
		end
	end

	// stage 2: far quad corner, sphere extent, pick hull points
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q3[i]  = sat_add(q1_s2[i], c_s2[i]);
			slo[i] = sat_sub(a_s2[i], r_s2);
			shi[i] = sat_add(a_s2[i], r_s2);
			case (cmd_s2)
				CMD_SPHERE: pt[i] = '{slo[i], shi[i], shi[i], shi[i]};
				CMD_QUAD:   pt[i] = '{a_s2[i], q1_s2[i], q2_s2[i], q3[i]};
				CMD_TRI:    pt[i] = '{a_s2[i], b_s2[i], c_s2[i], c_s2[i]};
				CMD_MERGE:  pt[i] = '{a_s2[i], b_s2[i], b_s2[i], b_s2[i]};
				default:    pt[i] = '{a_s2[i], b_s2[i], b_s2[i], b_s2[i]};
			endcase
		end
	end

	// stage 3: hull of four points per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo[i] = smin(smin(pt_s3[i][0], pt_s3[i][1]), smin(pt_s3[i][2], pt_s3[i][3]));
			hi[i] = smax(smax(pt_s3[i][0], pt_s3[i][1]), smax(pt_s3[i][2], pt_s3[i][3]));
		end
	end

	// stage 4: axes thinner than the pad
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			narrow[i] = padable_s4 &&
				(COORD_BITS'(hi_s4[i] - lo_s4[i]) < COORD_BITS'(pad));
		end
	end

	// stage 5: widen thin axes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo_o[i] = narrow_s5[i] ? sat_sub(lo_s5[i], pad_c) : lo_s5[i];
			hi_o[i] = narrow_s5[i] ? sat_add(hi_s5[i], pad_c) : hi_s5[i];
		end
		q_wdata.box.min_x = lo_o[0];
		q_wdata.box.min_y = lo_o[1];
		q_wdata.box.min_z = lo_o[2];
		q_wdata.box.max_x = hi_o[0];
		q_wdata.box.max_y = hi_o[1];
		q_wdata.box.max_z = hi_o[2];
		q_wdata.last      = last_s5;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1    <= item;
			cmd_s2     <= item_s1.cmd;
			last_s2    <= item_s1.last;
			a_s2       <= a;
			b_s2       <= b;
			c_s2       <= c;
			q1_s2      <= q1;
			q2_s2      <= q2;
			r_s2       <= abs_sat(item_s1.b_x);
			pt_s3      <= pt;
			last_s3    <= last_s2;
			padable_s3 <= (cmd_s2 == CMD_QUAD) || (cmd_s2 == CMD_TRI);
			lo_s4      <= lo;
			hi_s4      <= hi;
			last_s4    <= last_s3;
			padable_s4 <= padable_s3;
			lo_s5      <= lo_s4;
			hi_s5      <= hi_s4;
			narrow_s5  <= narrow;
			last_s5    <= last_s4;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pba_queue.sv =====
// Short queue of item boxes between the front pipeline and the accumulator.
// Depends on pba_pkg.
`default_nettype none

module pba_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pba_pkg::qword_t wdata,
	output logic            full,
	input  logic            pop,
	output pba_pkg::qword_t rdata,
	output logic            nempty
);
	import pba_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qword_t           mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign nempty  = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && nempty;
	assign rdata   = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pba_back.sv =====
// Back end: unions item boxes into the node box and holds finished results.
// Depends on pba_pkg; drains pba_queue.
`default_nettype none

module pba_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nempty,
	input  pba_pkg::qword_t q_rdata,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output pba_pkg::box_t   box
);
	import pba_pkg::*;

	localparam box_t ACC_RESET = '{
		min_x: COORD_MAX, min_y: COORD_MAX, min_z: COORD_MAX,
		max_x: COORD_MIN, max_y: COORD_MIN, max_z: COORD_MIN
	};

	box_t acc_q;
	box_t box_q;
	box_t merged;
	logic out_v_q;

	// take a word when the result slot is free or being emptied
	assign q_pop = q_nempty && (!out_v_q || pop);
	assign empty = !out_v_q;
	assign box   = box_q;

	// union of running box and incoming word
	always_comb begin
		merged.min_x = smin(acc_q.min_x, q_rdata.box.min_x);
		merged.min_y = smin(acc_q.min_y, q_rdata.box.min_y);
		merged.min_z = smin(acc_q.min_z, q_rdata.box.min_z);
		merged.max_x = smax(acc_q.max_x, q_rdata.box.max_x);
		merged.max_y = smax(acc_q.max_y, q_rdata.box.max_y);
		merged.max_z = smax(acc_q.max_z, q_rdata.box.max_z);
	end

	// accumulator and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= ACC_RESET;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_q <= q_rdata.last ? ACC_RESET : merged;
			end
			if (q_pop && q_rdata.last) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (q_pop && q_rdata.last) begin
			box_q <= merged;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pba_checker.sv =====
// Port-level checks for the bounds accumulator, bound to the top level.
// Depends on pba_pkg and primitive_bounds_accumulator_top_macros.svh.
`default_nettype none
`include "primitive_bounds_accumulator_top_macros.svh"

module pba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pop,
	input logic                       empty,
	input pba_pkg::box_t              box,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [pba_pkg::ADDR_W-1:0] paddr,
	input logic [pba_pkg::DATA_W-1:0] pwdata,
	input logic [pba_pkg::DATA_W-1:0] prdata,
	input logic                       pready
);
	import pba_pkg::*;

	// a waiting result stays put until popped
	`PBA_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(box), "result changed before pop")

	// every emitted box is ordered on all three axes
	`PBA_ASSERT_NOW(a_box_order, !empty, (box.min_x <= box.max_x) && (box.min_y <= box.max_y) && (box.min_z <= box.max_z), "result box has min above max")

	// a pad write reads back on the next cycle
	`PBA_ASSERT_NEXT(a_pad_readback, psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_PAD_AMOUNT), (paddr[ADDR_W-1:2] != REG_PAD_AMOUNT) || (prdata[PAD_W-1:0] == $past(pwdata[PAD_W-1:0])), "pad_amount readback mismatch")

endmodule

bind primitive_bounds_accumulator_top pba_checker u_pba_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.pop     (pop),
	.empty   (empty),
	.box     (box),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for primitive_bounds_accumulator_top: random and directed
// primitive words, node boxes predicted in-bench and compared field by field.
// Depends on pba_pkg and the RTL of the block only.
module tb_top;
	import pba_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned PHASE_WORDS = 240;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	item_t             in_word = '0;
	logic              pop = 1'b0;
	logic              empty;
	box_t              out_box;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// bench copy of the block state
	pad_t   pad_now = PAD_RESET;
	coord_t node_lo [0:2];
	coord_t node_hi [0:2];

	item_t  words_to_send [$];
	box_t   boxes_due [$];
	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned fails = 0;
	int unsigned cycle_count = 0;

	int unsigned tx_wait = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_calm = 0;
	logic        rx_hold = 1'b0;
	logic        hold_go = 1'b0;

	primitive_bounds_accumulator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(in_word),
		.pop(pop),
		.empty(empty),
		.box(out_box),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic coord_t clamp_add(input coord_t x, input longint y);
		longint s;
		s = longint'(x) + y;
		if (s > longint'(COORD_MAX)) begin
			return COORD_MAX;
		end
		if (s < longint'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return coord_t'(s);
	endfunction

	function automatic void clear_node();
		for (int i = 0; i < 3; i++) begin
			node_lo[i] = COORD_MAX;
			node_hi[i] = COORD_MIN;
		end
	endfunction

	// box of one word, unioned into the node; a last word closes the node
	task automatic fold_word(input item_t it);
		coord_t pa [0:2];
		coord_t pb [0:2];
		coord_t pc [0:2];
		coord_t pts [0:3][0:2];
		coord_t lo [0:2];
		coord_t hi [0:2];
		coord_t r;
		longint span;
		int n;
		box_t done;
		pa[0] = it.a_x; pa[1] = it.a_y; pa[2] = it.a_z;
		pb[0] = it.b_x; pb[1] = it.b_y; pb[2] = it.b_z;
		pc[0] = it.c_x; pc[1] = it.c_y; pc[2] = it.c_z;
		n = 0;
		r = it.b_x;
		if (r == COORD_MIN) begin
			r = COORD_MAX;
		end else if (r < 0) begin
			r = -r;
		end
		for (int i = 0; i < 3; i++) begin
			lo[i] = COORD_MAX;
			hi[i] = COORD_MIN;
			pts[0][i] = pa[i];
			case (it.cmd)
				CMD_SPHERE: begin
					lo[i] = clamp_add(pa[i], -longint'(r));
					hi[i] = clamp_add(pa[i], longint'(r));
				end
				CMD_QUAD: begin
					n = 4;
					pts[1][i] = clamp_add(pa[i], pb[i]);
					pts[2][i] = clamp_add(pa[i], pc[i]);
					pts[3][i] = clamp_add(pts[1][i], pc[i]);
				end
				CMD_TRI: begin
					n = 3;
					pts[1][i] = pb[i];
					pts[2][i] = pc[i];
				end
				default: begin
					n = 2;
					pts[1][i] = pb[i];
				end
			endcase
			for (int k = 0; k < n; k++) begin
				if (pts[k][i] < lo[i]) lo[i] = pts[k][i];
				if (pts[k][i] > hi[i]) hi[i] = pts[k][i];
			end
			// thin axes of quads and triangles get widened both ways
			if (it.cmd == CMD_QUAD || it.cmd == CMD_TRI) begin
				span = longint'(hi[i]) - longint'(lo[i]);
				if (span < longint'(pad_now)) begin
					lo[i] = clamp_add(lo[i], -longint'(pad_now));
					hi[i] = clamp_add(hi[i], longint'(pad_now));
				end
			end
			if (lo[i] < node_lo[i]) node_lo[i] = lo[i];
			if (hi[i] > node_hi[i]) node_hi[i] = hi[i];
		end
		if (it.last) begin
			done.min_x = node_lo[0];
			done.min_y = node_lo[1];
			done.min_z = node_lo[2];
			done.max_x = node_hi[0];
			done.max_y = node_hi[1];
			done.max_z = node_hi[2];
			boxes_due.insert(boxes_due.size(), done);
			clear_node();
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic cmp_coord(input string name, input coord_t want, input coord_t got);
		if (want !== got) begin
			fails++;
			if (fails <= 10) begin
				$display("box %s mismatch: expected %0d got %0d", name, want, got);
			end
		end
	endtask

	task automatic check_box(input box_t got);
		box_t want;
		if (boxes_due.size() == 0) begin
			fails++;
			if (fails <= 10) begin
				$display("box %h popped with none expected", got);
			end
		end else begin
			want = boxes_due.pop_front();
			cmp_coord("min_x", want.min_x, got.min_x);
			cmp_coord("min_y", want.min_y, got.min_y);
			cmp_coord("min_z", want.min_z, got.min_z);
			cmp_coord("max_x", want.max_x, got.max_x);
			cmp_coord("max_y", want.max_y, got.max_y);
			cmp_coord("max_z", want.max_z, got.max_z);
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	// idle length after a word: mostly none or short, now and then long,
	// with calm stretches that have no idling at all
	task automatic draw_gap(inout int unsigned calm, output int unsigned gap);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else begin
			if (roll < 55) gap = 0;
			else if (roll < 90) gap = $urandom_range(1, 3);
			else if (roll < 98) gap = $urandom_range(4, 12);
			else gap = $urandom_range(20, 60);
			if ($urandom_range(0, 59) == 0) calm = $urandom_range(20, 80);
		end
	endtask

	function automatic coord_t any_coord();
		case ($urandom_range(0, 5))
			0: return COORD_MAX - coord_t'($urandom_range(0, 255));
			1: return COORD_MIN + coord_t'($urandom_range(0, 255));
			2, 3: return coord_t'($urandom_range(0, 32'h1F_FFFF)) - coord_t'(32'h10_0000);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// offsets clustered around the padding threshold
	function automatic longint near_offset();
		longint p;
		longint d;
		p = longint'(pad_now);
		case ($urandom_range(0, 6))
			0: d = 0;
			1: d = p - 1;
			2: d = p;
			3: d = p + 1;
			4: d = $urandom_range(0, 2 * pad_now + 2);
			5: d = $urandom_range(0, 4095);
			default: d = longint'($signed($urandom));
		endcase
		return ($urandom_range(0, 1) == 1) ? -d : d;
	endfunction

	function automatic item_t rand_word(input logic lst);
		item_t it;
		coord_t a [0:2];
		coord_t b [0:2];
		coord_t c [0:2];
		logic wild;
		it.cmd = cmd_t'($urandom_range(0, 3));
		wild = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < 3; i++) begin
			a[i] = any_coord();
			if (wild) begin
				b[i] = coord_t'($urandom);
				c[i] = coord_t'($urandom);
			end else if (it.cmd == CMD_SPHERE || it.cmd == CMD_QUAD) begin
				// radius or edges
				b[i] = coord_t'(near_offset());
				c[i] = coord_t'(near_offset());
			end else begin
				// points near the first one; merges may come inverted
				b[i] = coord_t'(longint'(a[i]) + near_offset());
				c[i] = coord_t'(longint'(a[i]) + near_offset());
			end
		end
		it.a_x = a[0]; it.a_y = a[1]; it.a_z = a[2];
		it.b_x = b[0]; it.b_y = b[1]; it.b_z = b[2];
		it.c_x = c[0]; it.c_y = c[1]; it.c_z = c[2];
		it.last = lst;
		return it;
	endfunction

	task automatic send(input item_t it);
		words_to_send.insert(words_to_send.size(), it);
		words_queued++;
	endtask

	task automatic prim(input cmd_t op,
			input coord_t ax, input coord_t ay, input coord_t az,
			input coord_t bx, input coord_t by, input coord_t bz,
			input coord_t cx, input coord_t cy, input coord_t cz, input logic lst);
		item_t it;
		it.cmd = op;
		it.a_x = ax; it.a_y = ay; it.a_z = az;
		it.b_x = bx; it.b_y = by; it.b_z = bz;
		it.c_x = cx; it.c_y = cy; it.c_z = cz;
		it.last = lst;
		send(it);
	endtask

	// nodes of random length, mostly short
	task automatic queue_random(input int unsigned count);
		int unsigned left;
		left = 0;
		for (int unsigned k = 0; k < count; k++) begin
			if (left == 0) begin
				left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
			end
			left--;
			send(rand_word(left == 0 || k == count - 1));
		end
	endtask

	task automatic queue_directed();
		// sphere: zero radius, most negative radius, saturating edges, negative radius
		prim(CMD_SPHERE, 0, 0, 0, 0, 7, -7, 5, 5, 5, 1'b1);
		prim(CMD_SPHERE, 0, 100, -100, COORD_MIN, 0, 0, 0, 0, 0, 1'b1);
		prim(CMD_SPHERE, COORD_MAX, COORD_MIN, 0, 5, -1, -1, -1, -1, -1, 1'b0);
		prim(CMD_SPHERE, 100, -100, 65536, -10, 0, 0, 0, 0, 0, 1'b1);
		// quad: degenerate, extent equal to pad, saturating corners
		prim(CMD_QUAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		prim(CMD_QUAD, 10, 10, 10, 1, 0, 0, 0, 1, 0, 1'b1);
		prim(CMD_QUAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, -5,
			0, COORD_MAX, -5, 1'b0);
		prim(CMD_QUAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, -1, 3,
			-1, COORD_MIN, 3, 1'b1);
		// triangle: all at the extremes, thin and not-thin axes, full-range extent
		prim(CMD_TRI, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		prim(CMD_TRI, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		prim(CMD_TRI, 0, 0, 0, 1, 0, 2, 0, -1, 2, 1'b1);
		prim(CMD_TRI, 5, 5, 5, 5, 5, 5, 5, 5, 6, 1'b1);
		prim(CMD_TRI, COORD_MAX, 0, -7, COORD_MIN, 0, -7, 0, 0, -7, 1'b1);
		// merge: normal, min above max, full range, all-zero and all-one fields
		prim(CMD_MERGE, -100, -200, -300, 100, 200, 300, -1, -1, -1, 1'b1);
		prim(CMD_MERGE, 100, 200, 300, -100, -200, -300, 0, 0, 0, 1'b1);
		prim(CMD_MERGE, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			0, 0, 0, 1'b1);
		prim(CMD_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		prim(CMD_MERGE, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
		// one node built from every kind
		prim(CMD_SPHERE, 1000, 2000, 3000, 50, 0, 0, 0, 0, 0, 1'b0);
		prim(CMD_QUAD, -5000, 0, 0, 10, 0, 0, 0, 0, 10, 1'b0);
		prim(CMD_TRI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		prim(CMD_MERGE, 1, 1, 1, 2, 2, 2, 0, 0, 0, 1'b1);
	endtask

	task automatic write_pad(input pad_t v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_PAD_AMOUNT, 2'b00};
		pwdata <= {{(DATA_W - PAD_W){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pad_now = v;
	endtask

	// all words taken, all boxes back, then let words with no box drain
	task automatic settle();
		while (words_taken != words_queued || boxes_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				fold_word(in_word);
				words_taken++;
			end
			if (push && full) begin
				// stalled: keep the same word on offer
			end else if (tx_wait > 0) begin
				tx_wait--;
				push <= 1'b0;
			end else if (words_to_send.size() != 0) begin
				in_word <= words_to_send.pop_front();
				push <= 1'b1;
				draw_gap(tx_calm, tx_wait);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				check_box(out_box);
				draw_gap(rx_calm, rx_wait);
			end
			if (rx_hold || rx_wait > 0) begin
				if (rx_wait > 0) rx_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// long receiver stall so the queue fills and full backs up the input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		pad_t pad_plan [0:5];
		pad_plan[0] = '0;
		pad_plan[1] = '1;
		pad_plan[2] = pad_t'($urandom_range(0, 65535));
		pad_plan[3] = pad_t'($urandom_range(2, 64));
		pad_plan[4] = pad_t'(1);
		pad_plan[5] = pad_t'($urandom_range(0, 4096));
		clear_node();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under the reset padding
		queue_directed();
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			write_pad(pad_plan[ph]);
			if (ph == 1) hold_go = 1'b1;
			queue_random(PHASE_WORDS);
			settle();
		end

		if (fails == 0 && boxes_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
